[design/lap3_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 Laplacian sharpening unit.
package lap3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int LUMA_W     = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int HEIGHT_W   = ROW_W + 1;
  localparam int VAL_W      = 13;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // One column of the 3x3 window: two rows back, one row back, current row.
  typedef struct packed {
    logic [LUMA_W-1:0] top;
    logic [LUMA_W-1:0] mid;
    logic [LUMA_W-1:0] bot;
  } pix_col_t;

  // One entry of the line memory: the two previous rows at a column.
  typedef struct packed {
    logic [LUMA_W-1:0] above;
    logic [LUMA_W-1:0] middle;
  } line_pair_t;

endpackage

[design/lap3_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixel input and sharpened output.
interface lap3_in_if import lap3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma;
  logic              flush;

  modport source (output valid, output luma, output flush, input ready);
  modport sink (input valid, input luma, input flush, output ready);
endinterface

interface lap3_out_if import lap3_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sharp_value;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic                    frame_last;

  modport source (output valid, output sharp_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input sharp_value, input out_row, input out_col,
                input frame_last, output ready);
endinterface

[design/lap3_linebuf.sv]
`timescale 1ns / 1ps
// Line memory holding the two previous rows, one column per entry.
module lap3_linebuf import lap3_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  line_pair_t       wr_data,
  input  logic [COL_W-1:0] rd_addr,
  output line_pair_t       rd_data
);

  line_pair_t mem [MAX_WIDTH];

  // A read of the column being written in the same cycle takes the new data;
  // this happens when every row is a single pixel wide.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/lap3_cell.sv]
`timescale 1ns / 1ps
// One window column cell: holds three pixels and passes them on when the window moves.
module lap3_cell import lap3_pkg::*; (
  input  logic     clk,
  input  logic     shift,
  input  pix_col_t col_in,
  output pix_col_t col_q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

endmodule

[design/lap3_kernel.sv]
`timescale 1ns / 1ps
// Laplacian kernel arithmetic over the three window columns.
module lap3_kernel import lap3_pkg::*; (
  input  logic                    kernel_mode,
  input  pix_col_t                win_left,
  input  pix_col_t                win_center,
  input  pix_col_t                win_right,
  output logic signed [VAL_W-1:0] value
);

  logic [VAL_W-1:0] ctr;
  logic [VAL_W-1:0] edges;
  logic [VAL_W-1:0] corners;
  logic [VAL_W-1:0] result;

  // Two's complement wrap in VAL_W bits is exact since every result fits.
  always_comb begin
    ctr     = VAL_W'(win_center.mid);
    edges   = VAL_W'(win_left.mid) + VAL_W'(win_right.mid)
            + VAL_W'(win_center.top) + VAL_W'(win_center.bot);
    corners = VAL_W'(win_left.top) + VAL_W'(win_left.bot)
            + VAL_W'(win_right.top) + VAL_W'(win_right.bot);
    if (kernel_mode) begin
      result = (ctr << 3) + ctr - edges - corners;
    end else begin
      result = (ctr << 2) + ctr - edges;
    end
  end

  assign value = signed'(result);

endmodule

[design/laplacian_sharpen_3x3_unit.sv]
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Laplacian sharpening unit.
//
//   port      dir   handshake        payload
//   pixels    in    valid / ready    luma, flush
//   results   out   valid / ready    sharp_value, out_row, out_col, frame_last
//   cfg_*     in    cfg_we           cfg_index, cfg_data
//
// One item per clock sustained unless the output stalls. A result leaves via
// the window cells, then the output register, after the item completing its
// window is accepted. The line memory is read ahead at the next column. Reset
// clears counters and valid flags and sets mode 0, 640 x 480, but not line
// memory or data registers. A stalled output register lets one more item in.
module laplacian_sharpen_3x3_unit import lap3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lap3_in_if.sink                pixels,
  lap3_out_if.source             results
);

  typedef enum logic [1:0] {PH_ROW0, PH_ROW1, PH_PRIMED} row_phase_t;

  // Configuration, kept as last valid column and row.
  logic              kernel_mode;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;

  logic [WIDTH_W-1:0]  cfg_fw;
  logic [HEIGHT_W-1:0] cfg_fh;

  logic [COL_W-1:0]  in_col;
  logic [COL_W-1:0]  in_col_next;
  row_phase_t        row_phase;
  logic [ROW_W-1:0]  emit_row;
  logic [COL_W-1:0]  emit_col;

  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic              s1_last;
  logic              s1_border;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic                    out_last;

  logic              in_fire;
  logic              out_free;
  logic              advance;
  logic              primed;
  logic              col_wrap;
  logic              emit_col_wrap;
  logic              emit_last;
  logic              emit_border;
  logic              cfg_restart;
  logic              frame_done;
  logic [LUMA_W-1:0] pix;

  line_pair_t              lb_rd;
  line_pair_t              lb_wr;
  pix_col_t                new_col;
  pix_col_t                win [3];
  logic signed [VAL_W-1:0] kernel_value;

  assign out_free = !out_valid || results.ready;
  assign advance  = s1_valid && out_free;
  assign pixels.ready = !s1_valid || out_free;
  assign in_fire  = pixels.valid && pixels.ready;

  assign cfg_fw = cfg_data[WIDTH_W-1:0];
  assign cfg_fh = cfg_data[HEIGHT_W-1:0];
  assign cfg_restart = cfg_we && (cfg_index == REG_KERNEL_MODE
                       || cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // The item becomes a result once one row and one pixel are buffered.
  assign primed        = (row_phase == PH_PRIMED) || (row_phase == PH_ROW1 && in_col != '0);
  assign col_wrap      = (in_col == w_last);
  assign emit_col_wrap = (emit_col == w_last);
  assign emit_last     = (emit_row == h_last) && emit_col_wrap;
  assign emit_border   = (emit_row == '0) || (emit_row == h_last)
                       || (emit_col == '0) || emit_col_wrap;
  assign frame_done    = in_fire && primed && emit_last;

  assign pix = pixels.flush ? '0 : pixels.luma;

  assign new_col.top = lb_rd.above;
  assign new_col.mid = lb_rd.middle;
  assign new_col.bot = pix;

  assign lb_wr.above  = lb_rd.middle;
  assign lb_wr.middle = pix;

  always_comb begin
    in_col_next = in_col;
    if (rst || cfg_restart || frame_done) begin
      in_col_next = '0;
    end else if (in_fire) begin
      in_col_next = col_wrap ? '0 : in_col + COL_W'(1);
    end
  end

  lap3_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (in_col),
    .wr_data (lb_wr),
    .rd_addr (in_col_next),
    .rd_data (lb_rd)
  );

  // win[2] is the newest column; columns move toward win[0].
  for (genvar j = 0; j < 3; j++) begin : g_cells
    if (j == 2) begin : g_head
      lap3_cell u_cell (.clk(clk), .shift(in_fire), .col_in(new_col), .col_q(win[j]));
    end else begin : g_body
      lap3_cell u_cell (.clk(clk), .shift(in_fire), .col_in(win[j+1]), .col_q(win[j]));
    end
  end

  lap3_kernel u_kernel (
    .kernel_mode (kernel_mode),
    .win_left    (win[0]),
    .win_center  (win[1]),
    .win_right   (win[2]),
    .value       (kernel_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= 1'b0;
      w_last      <= COL_W'(RESET_WIDTH - 1);
      h_last      <= ROW_W'(RESET_HEIGHT - 1);
      in_col      <= '0;
      row_phase   <= PH_ROW0;
      emit_row    <= '0;
      emit_col    <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      in_col <= in_col_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL_MODE: kernel_mode <= cfg_data[0];
          REG_FRAME_WIDTH: begin
            if (cfg_fw == '0) begin
              w_last <= '0;
            end else if (cfg_fw > WIDTH_W'(MAX_WIDTH)) begin
              w_last <= COL_W'(MAX_WIDTH - 1);
            end else begin
              w_last <= COL_W'(cfg_fw - WIDTH_W'(1));
            end
          end
          REG_FRAME_HEIGHT: begin
            if (cfg_fh == '0) begin
              h_last <= '0;
            end else if (cfg_fh > HEIGHT_W'(MAX_HEIGHT)) begin
              h_last <= ROW_W'(MAX_HEIGHT - 1);
            end else begin
              h_last <= ROW_W'(cfg_fh - HEIGHT_W'(1));
            end
          end
          default: ;
        endcase
      end

      if (cfg_restart || frame_done) begin
        row_phase <= PH_ROW0;
        emit_row  <= '0;
        emit_col  <= '0;
      end else if (in_fire) begin
        if (col_wrap) begin
          case (row_phase)
            PH_ROW0: row_phase <= PH_ROW1;
            PH_ROW1: row_phase <= PH_PRIMED;
            default: row_phase <= PH_PRIMED;
          endcase
        end
        if (primed) begin
          if (emit_col_wrap) begin
            emit_col <= '0;
            emit_row <= emit_row + ROW_W'(1);
          end else begin
            emit_col <= emit_col + COL_W'(1);
          end
        end
      end

      if (in_fire) begin
        s1_valid <= primed;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row    <= emit_row;
      s1_col    <= emit_col;
      s1_last   <= emit_last;
      s1_border <= emit_border;
    end
    if (advance) begin
      out_value <= s1_border ? '0 : kernel_value;
      out_row   <= s1_row;
      out_col   <= s1_col;
      out_last  <= s1_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.sharp_value = out_value;
  assign results.out_row     = out_row;
  assign results.out_col     = out_col;
  assign results.frame_last  = out_last;

  // The column counters never run past the configured frame size.
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    in_col <= w_last && emit_col <= w_last)
    else $error("column counter beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    emit_row <= h_last)
    else $error("result row beyond frame height");

  // A pending window item is never overwritten by a new accept.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |-> !in_fire)
    else $error("item accepted over a pending window item");

  // The frame-last result belongs to the bottom right pixel.
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_row == h_last && out_col == w_last))
    else $error("frame_last on a pixel that is not the final one");

endmodule
